>>> hdl/qspc_pkg.sv
package qspc_pkg;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int KIND_W  = 3;
    localparam int VAL_W   = 31;
    localparam int HALF_W  = 20;
    localparam int SPEED_W = 19;
    localparam int FILL_W  = 4;
    localparam int RESP_W  = 4;

    // Continuous half period is this constant divided by the speed.
    localparam logic [SPEED_W-1:0] HALF_NUMERATOR = SPEED_W'(500000);

    // Register reset values.
    localparam logic [HALF_W-1:0]  STEP_HALF_RESET = HALF_W'(1000);
    localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = SPEED_W'(3000);

    // Configuration register indexes.
    localparam logic REG_STEP_HALF = 1'b0;
    localparam logic REG_MAX_SPEED = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PING      = 3'd0,
        KIND_ENABLE    = 3'd1,
        KIND_DISABLE   = 3'd2,
        KIND_DIR       = 3'd3,
        KIND_STEP      = 3'd4,
        KIND_SET_SPEED = 3'd5,
        KIND_STOP      = 3'd6,
        KIND_STATUS    = 3'd7
    } kind_t;

    typedef enum logic [RESP_W-1:0] {
        RSP_NONE          = 4'd0,
        RSP_QUEUED        = 4'd1,
        RSP_QUEUE_FULL    = 4'd2,
        RSP_PONG          = 4'd3,
        RSP_ENABLED       = 4'd4,
        RSP_DISABLED      = 4'd5,
        RSP_DIR_SET       = 4'd6,
        RSP_STATUS        = 4'd7,
        RSP_STOPPED       = 4'd8,
        RSP_SPEED_ZERO    = 4'd9,
        RSP_SPEED_SET     = 4'd10,
        RSP_ERR_STEP_ACT  = 4'd11,
        RSP_ERR_BAD_SPEED = 4'd12,
        RSP_STEP_START    = 4'd13,
        RSP_ERR_STOP_REQ  = 4'd14,
        RSP_STEP_DONE     = 4'd15
    } resp_t;

    // Action codes of an input item.
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_ENQUEUE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KIND_W-1:0] command_kind;
        logic [VAL_W-1:0]  command_value;
    } item_t;

    typedef struct packed {
        resp_t              response;
        logic [VAL_W-1:0]   echo_value;
        logic               step_pin;
        logic               dir_pin;
        logic               enable_n_pin;
        logic [FILL_W-1:0]  queue_fill;
        logic               executor_busy;
        logic               pulse_active;
        logic [VAL_W-1:0]   pulses_remaining;
        logic               continuous_on;
        logic [SPEED_W-1:0] speed_now;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  val;
    } qentry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic enqueue;
        logic dequeue;
        logic exec;
        logic div_start;
        logic apply_speed;
        logic step_tick;
        logic cont_tick;
        logic capture;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic action;
        logic busy;
        logic queue_nonempty;
        logic speed_ok;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/qspc_div.sv
// Restoring divider: the fixed numerator over a 19-bit divisor, one quotient bit per cycle.
module qspc_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [qspc_pkg::SPEED_W-1:0]    divisor,
    output logic                            busy,
    output logic [qspc_pkg::SPEED_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(qspc_pkg::SPEED_W + 1);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [qspc_pkg::SPEED_W:0]    rem_reg, rem_next;
    logic [qspc_pkg::SPEED_W-1:0]  quot_reg, quot_next;
    logic [qspc_pkg::SPEED_W-1:0]  dvs_reg, dvs_next;
    logic [qspc_pkg::SPEED_W:0]    shifted;
    logic [qspc_pkg::SPEED_W+1:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[qspc_pkg::SPEED_W-1:0], quot_reg[qspc_pkg::SPEED_W-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(qspc_pkg::SPEED_W);
            rem_next  = '0;
            quot_next = qspc_pkg::HALF_NUMERATOR;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[qspc_pkg::SPEED_W+1])
            begin
                rem_next  = trial[qspc_pkg::SPEED_W:0];
                quot_next = {quot_reg[qspc_pkg::SPEED_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[qspc_pkg::SPEED_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

>>> hdl/qspc_dp.sv
// Datapath: configuration registers, command queue, pulse generators and result register.
module qspc_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qspc_pkg::ctrl_cmd_t   cmd,
    output qspc_pkg::dp_stat_t    stat,
    input  qspc_pkg::item_t       item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output qspc_pkg::result_t     result,
    output logic                  result_valid,
    input  logic                  result_ready
);

    localparam int QPTR_W  = qspc_pkg::QPTR_W;
    localparam int QCNT_W  = qspc_pkg::QCNT_W;
    localparam int HALF_W  = qspc_pkg::HALF_W;
    localparam int SPEED_W = qspc_pkg::SPEED_W;
    localparam int VAL_W   = qspc_pkg::VAL_W;

    // Configuration.
    logic [HALF_W-1:0]  step_half_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic               cfg_write;

    // Queue.
    qspc_pkg::qentry_t  queue_mem [qspc_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]  head_reg, head_next;
    logic [QPTR_W-1:0]  tail_reg, tail_next;
    logic [QCNT_W-1:0]  used_reg, used_next;
    logic               queue_at_depth;

    // Current item and dequeued command.
    qspc_pkg::item_t    item_reg;
    qspc_pkg::qentry_t  cur_reg;

    // Executor state.
    logic               busy_reg, busy_next;
    logic               pulse_run_reg, pulse_run_next;
    logic               pulse_high_reg, pulse_high_next;
    logic [VAL_W-1:0]   pulses_left_reg, pulses_left_next;
    logic [HALF_W-1:0]  pulse_elapsed_reg, pulse_elapsed_next;
    logic [HALF_W-1:0]  pulse_half_reg, pulse_half_next;
    logic               cont_on_reg, cont_on_next;
    logic               cont_high_reg, cont_high_next;
    logic [HALF_W-1:0]  cont_elapsed_reg, cont_elapsed_next;
    logic [SPEED_W-1:0] cont_half_reg, cont_half_next;
    logic [SPEED_W-1:0] cont_speed_reg, cont_speed_next;
    logic               step_level_reg, step_level_next;
    logic               dir_level_reg, dir_level_next;
    logic               enable_n_reg, enable_n_next;
    qspc_pkg::resp_t    resp_reg, resp_next;
    logic [VAL_W-1:0]   echo_reg, echo_next;

    // Result register.
    qspc_pkg::result_t  result_reg;
    logic               result_valid_reg;

    // Divider.
    logic                div_busy;
    logic [SPEED_W-1:0]  div_quot;

    logic [HALF_W-1:0]   pulse_inc;
    logic [HALF_W-1:0]   cont_inc;
    logic [VAL_W-1:0]    left_dec;

    qspc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (cur_reg.val[SPEED_W-1:0]),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == qspc_pkg::REG_MAX_SPEED) ? 32'(max_speed_reg)
                                                             : 32'(step_half_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_half_reg <= qspc_pkg::STEP_HALF_RESET;
            max_speed_reg <= qspc_pkg::MAX_SPEED_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == qspc_pkg::REG_MAX_SPEED)
            begin
                max_speed_reg <= pwdata[SPEED_W-1:0];
            end
            else
            begin
                step_half_reg <= pwdata[HALF_W-1:0];
            end
        end
    end

    assign queue_at_depth = (used_reg >= QCNT_W'(qspc_pkg::QUEUE_DEPTH));
    assign pulse_inc  = pulse_elapsed_reg + HALF_W'(pulse_elapsed_reg != '1);
    assign cont_inc   = cont_elapsed_reg + HALF_W'(cont_elapsed_reg != '1);
    assign left_dec   = (pulses_left_reg != '0) ? pulses_left_reg - VAL_W'(1) : pulses_left_reg;

    always_comb
    begin
        head_next          = head_reg;
        tail_next          = tail_reg;
        used_next          = used_reg;
        busy_next          = busy_reg;
        pulse_run_next     = pulse_run_reg;
        pulse_high_next    = pulse_high_reg;
        pulses_left_next   = pulses_left_reg;
        pulse_elapsed_next = pulse_elapsed_reg;
        pulse_half_next    = pulse_half_reg;
        cont_on_next       = cont_on_reg;
        cont_high_next     = cont_high_reg;
        cont_elapsed_next  = cont_elapsed_reg;
        cont_half_next     = cont_half_reg;
        cont_speed_next    = cont_speed_reg;
        step_level_next    = step_level_reg;
        dir_level_next     = dir_level_reg;
        enable_n_next      = enable_n_reg;
        resp_next          = resp_reg;
        echo_next          = echo_reg;

        if (cmd.latch)
        begin
            resp_next = qspc_pkg::RSP_NONE;
            echo_next = '0;
        end

        if (cmd.enqueue)
        begin
            echo_next = item_reg.command_value;
            if (queue_at_depth)
            begin
                resp_next = qspc_pkg::RSP_QUEUE_FULL;
            end
            else
            begin
                tail_next = (tail_reg == QPTR_W'(qspc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : tail_reg + QPTR_W'(1);
                used_next = used_reg + QCNT_W'(1);
                resp_next = qspc_pkg::RSP_QUEUED;
            end
        end

        if (cmd.dequeue)
        begin
            head_next = (head_reg == QPTR_W'(qspc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : head_reg + QPTR_W'(1);
            used_next = used_reg - QCNT_W'(1);
        end

        // Every command except a speed change that passes its checks completes here.
        if (cmd.exec)
        begin
            echo_next = cur_reg.val;
            case (qspc_pkg::kind_t'(cur_reg.kind))
                qspc_pkg::KIND_PING:
                begin
                    resp_next = qspc_pkg::RSP_PONG;
                end
                qspc_pkg::KIND_ENABLE:
                begin
                    enable_n_next = 1'b0;
                    resp_next     = qspc_pkg::RSP_ENABLED;
                end
                qspc_pkg::KIND_DISABLE:
                begin
                    cont_on_next    = 1'b0;
                    cont_speed_next = '0;
                    cont_half_next  = '0;
                    cont_high_next  = 1'b0;
                    step_level_next = 1'b0;
                    enable_n_next   = 1'b1;
                    resp_next       = qspc_pkg::RSP_DISABLED;
                end
                qspc_pkg::KIND_DIR:
                begin
                    dir_level_next = (cur_reg.val != '0);
                    resp_next      = qspc_pkg::RSP_DIR_SET;
                end
                qspc_pkg::KIND_STEP:
                begin
                    if (cont_on_reg)
                    begin
                        resp_next = qspc_pkg::RSP_ERR_STOP_REQ;
                    end
                    else
                    begin
                        pulses_left_next   = cur_reg.val;
                        pulse_high_next    = 1'b0;
                        pulse_run_next     = 1'b1;
                        pulse_half_next    = step_half_reg;
                        pulse_elapsed_next = '0;
                        step_level_next    = 1'b0;
                        busy_next          = 1'b1;
                        resp_next          = qspc_pkg::RSP_STEP_START;
                    end
                end
                qspc_pkg::KIND_SET_SPEED:
                begin
                    if (pulse_run_reg)
                    begin
                        resp_next = qspc_pkg::RSP_ERR_STEP_ACT;
                    end
                    else if (cur_reg.val == '0)
                    begin
                        cont_on_next    = 1'b0;
                        cont_speed_next = '0;
                        cont_half_next  = '0;
                        cont_high_next  = 1'b0;
                        step_level_next = 1'b0;
                        resp_next       = qspc_pkg::RSP_SPEED_ZERO;
                    end
                    else
                    begin
                        resp_next = qspc_pkg::RSP_ERR_BAD_SPEED;
                    end
                end
                qspc_pkg::KIND_STOP:
                begin
                    cont_on_next    = 1'b0;
                    cont_speed_next = '0;
                    cont_half_next  = '0;
                    cont_high_next  = 1'b0;
                    step_level_next = 1'b0;
                    resp_next       = qspc_pkg::RSP_STOPPED;
                end
                default:
                begin
                    resp_next = qspc_pkg::RSP_STATUS;
                end
            endcase
        end

        // A speed above the numerator gives a zero quotient; the half period then becomes one.
        if (cmd.apply_speed)
        begin
            echo_next          = cur_reg.val;
            cont_on_next       = 1'b1;
            cont_speed_next    = cur_reg.val[SPEED_W-1:0];
            cont_half_next     = (div_quot == '0) ? SPEED_W'(1) : div_quot;
            cont_high_next     = 1'b0;
            cont_elapsed_next  = '0;
            step_level_next    = 1'b0;
            resp_next          = qspc_pkg::RSP_SPEED_SET;
        end

        // Finite pulse train: low half, then high half; each falling edge uses one pulse.
        if (cmd.step_tick && pulse_run_reg)
        begin
            if (pulse_inc < pulse_half_reg)
            begin
                pulse_elapsed_next = pulse_inc;
            end
            else
            begin
                pulse_elapsed_next = '0;
                if (!pulse_high_reg)
                begin
                    pulse_high_next = 1'b1;
                    step_level_next = 1'b1;
                end
                else
                begin
                    pulse_high_next  = 1'b0;
                    step_level_next  = 1'b0;
                    pulses_left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        pulse_run_next = 1'b0;
                        busy_next      = 1'b0;
                        resp_next      = qspc_pkg::RSP_STEP_DONE;
                    end
                end
            end
        end

        if (cmd.cont_tick && cont_on_reg && (cont_half_reg != '0) && !pulse_run_reg)
        begin
            if (cont_inc < HALF_W'(cont_half_reg))
            begin
                cont_elapsed_next = cont_inc;
            end
            else
            begin
                cont_elapsed_next = '0;
                cont_high_next    = !cont_high_reg;
                step_level_next   = !cont_high_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg          <= '0;
            tail_reg          <= '0;
            used_reg          <= '0;
            busy_reg          <= 1'b0;
            pulse_run_reg     <= 1'b0;
            pulse_high_reg    <= 1'b0;
            pulses_left_reg   <= '0;
            pulse_elapsed_reg <= '0;
            pulse_half_reg    <= qspc_pkg::STEP_HALF_RESET;
            cont_on_reg       <= 1'b0;
            cont_high_reg     <= 1'b0;
            cont_elapsed_reg  <= '0;
            cont_half_reg     <= '0;
            cont_speed_reg    <= '0;
            step_level_reg    <= 1'b0;
            dir_level_reg     <= 1'b0;
            enable_n_reg      <= 1'b1;
            resp_reg          <= qspc_pkg::RSP_NONE;
            echo_reg          <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            used_reg          <= used_next;
            busy_reg          <= busy_next;
            pulse_run_reg     <= pulse_run_next;
            pulse_high_reg    <= pulse_high_next;
            pulses_left_reg   <= pulses_left_next;
            pulse_elapsed_reg <= pulse_elapsed_next;
            pulse_half_reg    <= pulse_half_next;
            cont_on_reg       <= cont_on_next;
            cont_high_reg     <= cont_high_next;
            cont_elapsed_reg  <= cont_elapsed_next;
            cont_half_reg     <= cont_half_next;
            cont_speed_reg    <= cont_speed_next;
            step_level_reg    <= step_level_next;
            dir_level_reg     <= dir_level_next;
            enable_n_reg      <= enable_n_next;
            resp_reg          <= resp_next;
            echo_reg          <= echo_next;
            if (cmd.capture)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload storage: input latch, queue memory with registered read, result snapshot.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.enqueue && !queue_at_depth)
        begin
            queue_mem[tail_reg] <= '{kind: item_reg.command_kind, val: item_reg.command_value};
        end
        if (cmd.dequeue)
        begin
            cur_reg <= queue_mem[head_reg];
        end
        if (cmd.capture)
        begin
            result_reg.response         <= resp_reg;
            result_reg.echo_value       <= echo_reg;
            result_reg.step_pin         <= step_level_reg;
            result_reg.dir_pin          <= dir_level_reg;
            result_reg.enable_n_pin     <= enable_n_reg;
            result_reg.queue_fill       <= qspc_pkg::FILL_W'(used_reg);
            result_reg.executor_busy    <= busy_reg;
            result_reg.pulse_active     <= pulse_run_reg;
            result_reg.pulses_remaining <= pulses_left_reg;
            result_reg.continuous_on    <= cont_on_reg;
            result_reg.speed_now        <= cont_speed_reg;
        end
    end

    assign stat.action         = item_reg.action;
    assign stat.busy           = busy_reg;
    assign stat.queue_nonempty = (used_reg != '0);
    assign stat.speed_ok       = (qspc_pkg::kind_t'(cur_reg.kind) == qspc_pkg::KIND_SET_SPEED)
                                 && (cur_reg.val != '0)
                                 && (cur_reg.val <= VAL_W'(max_speed_reg))
                                 && !pulse_run_reg;
    assign stat.div_busy       = div_busy;
    assign stat.out_free       = !result_valid_reg || result_ready;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> hdl/qspc_ctrl.sv
// Controller: sequences the phases of one item through the datapath.
module qspc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  qspc_pkg::dp_stat_t    stat,
    output qspc_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_STEP   = 7'b0010000,
        ST_CONT   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.action == qspc_pkg::ACT_ENQUEUE)
                begin
                    cmd.enqueue = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (stat.busy)
                begin
                    state_next = ST_STEP;
                end
                else if (stat.queue_nonempty)
                begin
                    cmd.dequeue = 1'b1;
                    state_next  = ST_EXEC;
                end
                else
                begin
                    state_next = ST_CONT;
                end
            end
            ST_EXEC:
            begin
                if (stat.speed_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_CONT;
                end
            end
            ST_DIV:
            begin
                // Speed generator skips its tick on the tick that starts it.
                if (!stat.div_busy)
                begin
                    cmd.apply_speed = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_STEP:
            begin
                cmd.step_tick = 1'b1;
                state_next    = ST_CONT;
            end
            ST_CONT:
            begin
                cmd.cont_tick = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/queued_stepper_pulse_controller.sv
// Channel   Handshake                        Payload
// item      item_valid / item_ready          item   (qspc_pkg::item_t)
// result    result_valid / result_ready      result (qspc_pkg::result_t)
// config    psel, penable, pwrite, pready    paddr, pwdata, prdata (APB-style)
//
// The controller takes an item when idle and works on it in phases: an enqueue
// passes decode and finish; a tick passes decode, a step or execute phase if
// one applies, the continuous phase and finish; a tick that starts a speed waits
// on the one-bit-per-cycle divider for the half period. One item is in work at
// a time; the result register lets the next item in while an older result waits.
// Reset is asynchronous and active low; the queue holds no entries after reset.
module queued_stepper_pulse_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  qspc_pkg::item_t      item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output qspc_pkg::result_t    result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Commands flow from the controller to the datapath; status flows back.
    qspc_pkg::ctrl_cmd_t  cmd;
    qspc_pkg::dp_stat_t   stat;

    // The controller owns the item handshake and the phase sequence.
    qspc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath holds the queue, both pulse generators, the pin levels,
    // the configuration registers and the result register.
    qspc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
